// ----- src/scs_pkg.sv -----
package scs_pkg;

   localparam int CODE_W  = 16;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic sample;
   } scan_ctl_type;

endpackage

// ----- src/scs_ram.sv -----
module scs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/scs_cmp.sv -----
module scs_cmp (
   input  logic                       clock,
   input  logic                       reset,
   input  scs_pkg::scan_ctl_type      ctl,
   input  logic [scs_pkg::CODE_W-1:0] key,
   input  logic [scs_pkg::CODE_W-1:0] data,
   output logic                       hit
);

   logic [scs_pkg::CODE_W-1:0] key_ff;
   logic [scs_pkg::CODE_W-1:0] key_in;
   logic                       hit_ff;
   logic                       hit_in;

   always_comb begin
      key_in = key_ff;
      hit_in = hit_ff;
      if (ctl.start) begin
         key_in = key;
         hit_in = 1'b0;
      end else if (ctl.sample && (data == key_ff)) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ----- src/searchable_code_stack.sv -----
// channel  handshake           payload
// req      req_valid/req_stall  req_operation, req_char_code
// rsp      rsp_valid/rsp_stall  rsp_popped_code, rsp_pop_valid, rsp_found,
//                               rsp_push_rejected, rsp_entry_count
//
// push, clear and ops on an empty stack answer from idle; pop reads the ram first,
// search walks the n held codes: one compare per cycle against the registered ram read
// one transaction at a time; req_stall is high while an operation runs or the
// result register is full and stalled
// synchronous active-high reset empties the stack; ram contents are not cleared
module searchable_code_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [scs_pkg::CODE_W-1:0]  req_char_code,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [scs_pkg::CODE_W-1:0]  rsp_popped_code,
   output logic                        rsp_pop_valid,
   output logic                        rsp_found,
   output logic                        rsp_push_rejected,
   output logic [scs_pkg::COUNT_W-1:0] rsp_entry_count
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   scs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]  cnt_dec;
   logic [CNT_W-1:0]  scan_inc;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [scs_pkg::CODE_W-1:0] popped_ff, popped_in;
   logic                       pop_valid_ff, pop_valid_in;
   logic                       found_ff, found_in;
   logic                       rejected_ff, rejected_in;
   logic [scs_pkg::COUNT_W-1:0] entry_ff, entry_in;

   logic                       accept;
   logic                       out_free;
   logic                       load;
   logic                       wr_en;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [scs_pkg::CODE_W-1:0] rd_data;
   logic                       hit;
   scs_pkg::scan_ctl_type      scan_ctl;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != scs_pkg::ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign cnt_dec   = count_ff - CNT_W'(1);
   assign scan_inc  = scan_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      load         = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[ADDR_W-1:0];
      scan_ctl     = '0;
      popped_in    = '0;
      pop_valid_in = 1'b0;
      found_in     = 1'b0;
      rejected_in  = 1'b0;
      entry_in     = scs_pkg::COUNT_W'(count_ff);
      case (state_ff)
         scs_pkg::ST_IDLE: begin
            if (accept) begin
               case (scs_pkg::op_type'(req_operation))
                  scs_pkg::OP_PUSH: begin
                     load = 1'b1;
                     if (count_ff < CNT_W'(STACK_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        entry_in = scs_pkg::COUNT_W'(count_in);
                     end else begin
                        rejected_in = 1'b1;
                     end
                  end
                  scs_pkg::OP_POP: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_dec[ADDR_W-1:0];
                        count_in = cnt_dec;
                        state_in = scs_pkg::ST_POP_WAIT;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  scs_pkg::OP_CLEAR: begin
                     load     = 1'b1;
                     count_in = '0;
                     entry_in = '0;
                  end
                  scs_pkg::OP_SEARCH: begin
                     if (count_ff != '0) begin
                        scan_ctl.start = 1'b1;
                        scan_in        = '0;
                        state_in       = scs_pkg::ST_SCAN;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         scs_pkg::ST_POP_WAIT: begin
            popped_in    = rd_data;
            pop_valid_in = 1'b1;
            if (out_free) begin
               load     = 1'b1;
               state_in = scs_pkg::ST_IDLE;
            end
         end
         scs_pkg::ST_SCAN: begin
            rd_en           = 1'b1;
            cmp_vld_in      = 1'b1;
            scan_ctl.sample = cmp_vld_ff;
            scan_in         = scan_inc;
            if (scan_inc == count_ff) begin
               state_in = scs_pkg::ST_SCAN_LAST;
            end
         end
         scs_pkg::ST_SCAN_LAST: begin
            scan_ctl.sample = cmp_vld_ff;
            state_in        = scs_pkg::ST_DONE;
         end
         scs_pkg::ST_DONE: begin
            found_in = hit;
            if (out_free) begin
               load     = 1'b1;
               state_in = scs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scs_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scs_pkg::ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff <= scan_in;
      if (load) begin
         popped_ff    <= popped_in;
         pop_valid_ff <= pop_valid_in;
         found_ff     <= found_in;
         rejected_ff  <= rejected_in;
         entry_ff     <= entry_in;
      end
   end

   scs_ram #(
      .WIDTH (scs_pkg::CODE_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_char_code),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   scs_cmp u_cmp (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .key   (req_char_code),
      .data  (rd_data),
      .hit   (hit)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_code   = popped_ff;
   assign rsp_pop_valid     = pop_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_push_rejected = rejected_ff;
   assign rsp_entry_count   = entry_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == scs_pkg::OP_PUSH) && (count_ff < CNT_W'(STACK_DEPTH)))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the stack");

   a_scan_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scs_pkg::ST_SCAN) |-> !rsp_valid_ff)
      else $error("result register busy during search");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({pop_valid_ff, found_ff, rejected_ff}))
      else $error("more than one result flag set");

endmodule
